// ===== rtl/bmhq_pkg.sv =====
// Shared types and constants for the binary min-heap queue.
// Holds the payload structs, status codes, controller states and the
// command/flag structs between controller and datapath. No dependencies.
package bmhq_pkg;

    localparam int unsigned DEFAULT_DEPTH = 32;
    localparam int unsigned KEY_W         = 32;
    localparam int unsigned FILL_W        = 6;

    // Operation codes
    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic                    op;
        logic signed [KEY_W-1:0] key_in;
    } t_in;

    typedef struct packed {
        logic signed [KEY_W-1:0] key_out;
        t_status                 status;
        logic [FILL_W-1:0]       fill_level;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_EX_LD,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_REPORT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic latch_in;   // capture the input beat
        logic check;      // set status, clear result key
        logic ins_init;   // place hole at end, bump count
        logic ext_rd;     // read root and last entry
        logic ext_load;   // take root as result, last as moving key
        logic up_rd;      // read parent of hole
        logic up_mv;      // move parent down into hole
        logic dn_rd;      // read both children of hole
        logic dn_mv;      // move smaller child up into hole
        logic wr_key;     // drop moving key into hole
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_ext;
        logic full;
        logic empty;
        logic at_root;
        logic has_lc;
        logic parent_gt;
        logic child_lt;
    } t_flags;

endpackage

// ===== rtl/bmhq_ctrl.sv =====
// Sequencer for the binary min-heap queue: walks insert and extract
// through check, sift steps and report. Depends on bmhq_pkg.
module bmhq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  bmhq_pkg::t_flags i_flags,
    output logic            busy,
    output logic            o_done,
    output bmhq_pkg::t_cmd  o_cmd
);
    import bmhq_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_flags.is_ext) begin
                    n_state = i_flags.empty ? S_REPORT : S_EX_LD;
                end else begin
                    n_state = i_flags.full ? S_REPORT : S_UP_RD;
                end
            end
            S_EX_LD:  n_state = S_DN_RD;
            S_UP_RD:  n_state = i_flags.at_root ? S_REPORT : S_UP_CMP;
            S_UP_CMP: n_state = i_flags.parent_gt ? S_UP_RD : S_REPORT;
            S_DN_RD:  n_state = i_flags.has_lc ? S_DN_CMP : S_REPORT;
            S_DN_CMP: n_state = i_flags.child_lt ? S_DN_RD : S_REPORT;
            S_REPORT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Commands and status
    always_comb begin
        o_cmd  = '0;
        busy   = (r_state != S_IDLE);
        o_done = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.latch_in = start;
            end
            S_CHECK: begin
                o_cmd.check    = 1'b1;
                o_cmd.ins_init = !i_flags.is_ext && !i_flags.full;
                o_cmd.ext_rd   = i_flags.is_ext && !i_flags.empty;
            end
            S_EX_LD: begin
                o_cmd.ext_load = 1'b1;
            end
            S_UP_RD: begin
                o_cmd.wr_key = i_flags.at_root;
                o_cmd.up_rd  = !i_flags.at_root;
            end
            S_UP_CMP: begin
                o_cmd.up_mv  = i_flags.parent_gt;
                o_cmd.wr_key = !i_flags.parent_gt;
            end
            S_DN_RD: begin
                o_cmd.dn_rd  = i_flags.has_lc;
                o_cmd.wr_key = !i_flags.has_lc;
            end
            S_DN_CMP: begin
                o_cmd.dn_mv  = i_flags.child_lt;
                o_cmd.wr_key = !i_flags.child_lt;
            end
            S_REPORT: begin
                o_done = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/bmhq_dp.sv =====
// Datapath for the binary min-heap queue: key store, entry count, hole
// position, moving key and result registers. Depends on bmhq_pkg.
module bmhq_dp #(
    parameter int unsigned DEPTH = bmhq_pkg::DEFAULT_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bmhq_pkg::t_in    i_item,
    input  bmhq_pkg::t_cmd   i_cmd,
    output bmhq_pkg::t_flags o_flags,
    output bmhq_pkg::t_out   o_res
);
    import bmhq_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned IW = AW + 2;

    logic signed [KEY_W-1:0] r_mem [DEPTH];

    logic [CW-1:0]           r_count;
    logic                    r_op;
    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] r_root;
    t_status                 r_stat;
    logic [AW-1:0]           r_pos;
    logic signed [KEY_W-1:0] r_rd_a;
    logic signed [KEY_W-1:0] r_rd_b;

    logic [AW-1:0]           parent;
    logic [IW-1:0]           lc;
    logic [IW-1:0]           rc;
    logic [IW-1:0]           count_x;
    logic                    has_rc;
    logic                    pick_rc;
    logic signed [KEY_W-1:0] pick_val;
    logic [AW-1:0]           pick_pos;
    logic [AW-1:0]           rd_addr_a;
    logic [AW-1:0]           rd_addr_b;
    logic                    wr_en;
    logic signed [KEY_W-1:0] wr_data;
    logic [CW+FILL_W-1:0]    fill_x;

    // Tree index arithmetic
    assign parent   = (r_pos - AW'(1)) >> 1;
    assign lc       = {1'b0, r_pos, 1'b1};
    assign rc       = lc + IW'(1);
    assign count_x  = IW'(r_count);
    assign has_rc   = (rc < count_x);
    assign pick_rc  = has_rc && (r_rd_b < r_rd_a);
    assign pick_val = pick_rc ? r_rd_b : r_rd_a;
    assign pick_pos = pick_rc ? rc[AW-1:0] : lc[AW-1:0];

    // Status to the controller
    always_comb begin
        o_flags.is_ext    = (r_op == OP_EXTRACT);
        o_flags.full      = (r_count == CW'(DEPTH));
        o_flags.empty     = (r_count == '0);
        o_flags.at_root   = (r_pos == '0);
        o_flags.has_lc    = (lc < count_x);
        o_flags.parent_gt = (r_rd_a > r_key);
        o_flags.child_lt  = (pick_val < r_key);
    end

    // Read addresses
    always_comb begin
        rd_addr_a = parent;
        rd_addr_b = rc[AW-1:0];
        if (i_cmd.ext_rd) begin
            rd_addr_a = '0;
            rd_addr_b = AW'(r_count - CW'(1));
        end else if (i_cmd.dn_rd) begin
            rd_addr_a = lc[AW-1:0];
        end else if (i_cmd.up_rd) begin
            rd_addr_a = parent;
        end
    end

    // Write port: moving key or shifted entry into the hole
    assign wr_en   = i_cmd.wr_key || i_cmd.up_mv || i_cmd.dn_mv;
    assign wr_data = i_cmd.up_mv ? r_rd_a : (i_cmd.dn_mv ? pick_val : r_key);

    // Key store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_pos] <= wr_data;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.ins_init) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.ext_load) begin
            r_count <= r_count - CW'(1);
        end
    end

    // Operation, moving key, hole position and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op  <= i_item.op;
            r_key <= i_item.key_in;
        end
        if (i_cmd.check) begin
            r_root <= '0;
            if (r_op == OP_EXTRACT) begin
                r_stat <= o_flags.empty ? ST_EMPTY : ST_OK;
            end else begin
                r_stat <= o_flags.full ? ST_FULL : ST_OK;
            end
        end
        if (i_cmd.ins_init) begin
            r_pos <= AW'(r_count);
        end
        if (i_cmd.ext_load) begin
            r_root <= r_rd_a;
            r_key  <= r_rd_b;
            r_pos  <= '0;
        end
        if (i_cmd.up_mv) begin
            r_pos <= parent;
        end
        if (i_cmd.dn_mv) begin
            r_pos <= pick_pos;
        end
    end

    // Result beat
    assign fill_x           = {{FILL_W{1'b0}}, r_count};
    assign o_res.key_out    = r_root;
    assign o_res.status     = r_stat;
    assign o_res.fill_level = fill_x[FILL_W-1:0];

endmodule

// ===== rtl/binary_min_heap_queue.sv =====
// Top level of the binary min-heap queue of signed 32-bit keys.
// Joins controller bmhq_ctrl and datapath bmhq_dp; types from bmhq_pkg.
//
//   channel | ports                 | handshake
//   --------+-----------------------+-------------------------------
//   item in | i_item (t_in)         | taken when start && !busy
//   result  | o_res (t_out)         | o_done high one cycle, no stall
//
// An item is accepted, then checked; an extract then loads the root. Each level
// the hole moves takes one store read and one compare and move; then the moving
// key is dropped into the hole and the result reported. A hole moves at most
// log2(DEPTH) levels; a rejected item goes straight from check to report.
// Reset clears the count and the sequencer; store contents need no clearing.
// The receiver cannot stall a result.
module binary_min_heap_queue #(
    parameter int unsigned DEPTH = bmhq_pkg::DEFAULT_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  bmhq_pkg::t_in  i_item,
    output logic           busy,
    output logic           o_done,
    output bmhq_pkg::t_out o_res
);
    import bmhq_pkg::*;

    t_cmd   cmd;
    t_flags flags;

    bmhq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_flags (flags),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    bmhq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (cmd),
        .o_flags (flags),
        .o_res   (o_res)
    );

    // A result beat ends the item: the block is free next cycle
    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("block still busy after result beat");

    // An accepted item keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // Only an ok extract carries a key
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status != ST_OK) |-> (o_res.key_out == '0))
        else $error("rejected item carries a nonzero key");

    // A rejected insert leaves the heap full
    a_full_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status == ST_FULL) |->
            (o_res.fill_level == FILL_W'(DEPTH)))
        else $error("full status with heap not full");

endmodule
